// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the list block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ALID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("alid assertion failed");

// condition that must never hold outside reset
`define ALID_ASSERT_NEVER(lbl, cond) \
  `ALID_ASSERT(lbl, !(cond))

`endif

// ===== hw/rtl/alid_pkg.sv =====
// package with field widths, codes and cell control types of the list block
`timescale 1ns / 1ps

package alid_pkg;

  localparam int WORD_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 5;
  localparam int WIDX_W       = 4;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  // command modes
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UPD_VAL  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UPD_IDX  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // operation applied to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_WRITE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [WORD_W-1:0]   data;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/alid_if.sv =====
// command and result channel interfaces of the list block
`timescale 1ns / 1ps

interface alid_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [alid_pkg::MODE_W-1:0]  mode;
  logic        [alid_pkg::POS_W-1:0]   position;
  logic signed [alid_pkg::WORD_W-1:0]  new_word;
  logic signed [alid_pkg::WORD_W-1:0]  match_word;

  modport source(output valid, mode, position, new_word, match_word, input ready);
  modport sink(input valid, mode, position, new_word, match_word, output ready);
endinterface

interface alid_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [alid_pkg::WORD_W-1:0]   word_out;
  logic        [alid_pkg::WIDX_W-1:0]   word_index;
  logic        [alid_pkg::STATUS_W-1:0] status;
  logic        [alid_pkg::COUNT_W-1:0]  count_out;
  logic                                 last;

  modport source(output valid, word_out, word_index, status, count_out, last, input ready);
  modport sink(input valid, word_out, word_index, status, count_out, last, output ready);
endinterface

// ===== hw/rtl/alid_cell.sv =====
// one storage cell of the list chain, trading words with its neighbors
`timescale 1ns / 1ps

module alid_cell #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                          clk_i,
  input  alid_pkg::cell_ctl_t           ctl_i,
  input  logic [IDX_W-1:0]              pos_i,
  input  logic [IDX_W-1:0]              last_i,
  input  logic [alid_pkg::WORD_W-1:0]   left_i,
  input  logic [alid_pkg::WORD_W-1:0]   right_i,
  output logic [alid_pkg::WORD_W-1:0]   word_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [alid_pkg::WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      alid_pkg::CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          word_d = left_i;
        end else if (MyIdx == pos_i) begin
          word_d = ctl_i.data;
        end
      end
      alid_pkg::CELL_DELETE: begin
        if (MyIdx >= pos_i) begin
          word_d = right_i;
        end
      end
      alid_pkg::CELL_WRITE: begin
        if (MyIdx == pos_i) begin
          word_d = ctl_i.data;
        end
      end
      alid_pkg::CELL_ROTATE: begin
        // words move toward cell 0, the control word enters at the tail cell
        if (MyIdx < last_i) begin
          word_d = right_i;
        end else if (MyIdx == last_i) begin
          word_d = ctl_i.data;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== hw/rtl/array_list_insert_delete_update.sv =====
// top level of the bounded ordered list: command control and the cell chain
`timescale 1ns / 1ps
`include "assert_macros.svh"

// bounded ordered list of signed 32-bit words, held in a chain of cells
// - cmd_i (sink): one command item per handshake (mode, position, new_word,
//   match_word); ready is high only while no command is in progress
// - res_o (source): result items; traverse gives one per stored word with
//   last on the final one or one item when empty; others give exactly one
// - clear, insert, delete, update by index run in the exec state once the
//   output register is free, writing their result to it; insert and delete
//   shift all later cells at once, every cell acting on its neighbor's word
// - traverse: the chain rotates one place a cycle while the output register
//   is free and the head cell is read out, so the list is back in place
//   after the pass; update by value uses the same rotation, compares the
//   head word each cycle and swaps in the new word on the first hit
// - a command may be accepted while the previous result waits in the output
//   register; a stalled receiver holds the traverse rotation and any result
// - reset clears the count and the control state; cell contents are unknown
//   until written, and only words below the count are ever read

module array_list_insert_delete_update #(
  parameter int CAPACITY = alid_pkg::CAPACITY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  alid_cmd_if.sink   cmd_i,
  alid_res_if.source res_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > alid_pkg::POS_W) ? CNT_W : alid_pkg::POS_W;
  localparam int WORD_W = alid_pkg::WORD_W;

  // control states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_ROT    = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] rot_k_q, rot_k_d;
  logic found_q, found_d;
  logic [IDX_W-1:0] fidx_q, fidx_d;

  // latched command
  logic [alid_pkg::MODE_W-1:0] mode_q;
  logic [alid_pkg::POS_W-1:0]  pos_q;
  logic [WORD_W-1:0]           nw_q;
  logic [WORD_W-1:0]           mw_q;

  // output register
  logic                          ov_q;
  logic [WORD_W-1:0]             rword_q, rword_d;
  logic [IDX_W-1:0]              ridx_q, ridx_d;
  logic [alid_pkg::STATUS_W-1:0] rstat_q, rstat_d;
  logic [CNT_W-1:0]              rcnt_q;
  logic                          rlast_q, rlast_d;
  logic                          push;

  logic cmd_fire, slot_free, is_trav, hit, pos_bad;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic [IDX_W-1:0] pos_idx, ins_idx, last_idx;

  // cell chain
  alid_pkg::cell_ctl_t cell_ctl;
  logic [IDX_W-1:0]    cell_pos;
  logic [WORD_W-1:0]   cell_word [CAPACITY];

  assign cmd_fire  = cmd_i.valid && cmd_i.ready;
  assign slot_free = !ov_q || res_o.ready;
  assign is_trav   = (mode_q == alid_pkg::MODE_TRAVERSE);
  assign hit       = (cell_word[0] == mw_q);

  assign pos_ext  = CMP_W'(pos_q);
  assign cnt_ext  = CMP_W'(count_q);
  assign pos_bad  = (pos_ext >= cnt_ext);
  assign pos_idx  = IDX_W'(pos_q);
  // insert at or past the count appends
  assign ins_idx  = (pos_ext > cnt_ext) ? IDX_W'(count_q) : pos_idx;
  assign last_idx = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rot_k_d       = rot_k_q;
    found_d       = found_q;
    fidx_d        = fidx_q;
    cell_ctl.op   = alid_pkg::CELL_HOLD;
    cell_ctl.data = nw_q;
    cell_pos      = pos_idx;
    push          = 1'b0;
    rword_d       = '0;
    ridx_d        = '0;
    rstat_d       = alid_pkg::ST_OK;
    rlast_d       = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
          case (mode_q)
            alid_pkg::MODE_CLEAR: begin
              count_d = '0;
              push    = 1'b1;
            end
            alid_pkg::MODE_TRAVERSE: begin
              if (count_q == '0) begin
                push    = 1'b1;
                rstat_d = alid_pkg::ST_EMPTY;
              end else begin
                state_d = S_ROT;
                rot_k_d = '0;
              end
            end
            alid_pkg::MODE_INSERT: begin
              push = 1'b1;
              if (count_q == CNT_W'(CAPACITY)) begin
                rstat_d = alid_pkg::ST_FULL;
              end else begin
                cell_ctl.op = alid_pkg::CELL_INSERT;
                cell_pos    = ins_idx;
                count_d     = count_q + CNT_W'(1);
                ridx_d      = ins_idx;
              end
            end
            alid_pkg::MODE_DELETE: begin
              push = 1'b1;
              if (pos_bad) begin
                rstat_d = alid_pkg::ST_INVALID;
              end else begin
                cell_ctl.op = alid_pkg::CELL_DELETE;
                count_d     = count_q - CNT_W'(1);
                ridx_d      = pos_idx;
              end
            end
            alid_pkg::MODE_UPD_VAL: begin
              if (count_q == '0) begin
                push    = 1'b1;
                rstat_d = alid_pkg::ST_NOTFOUND;
              end else begin
                state_d = S_ROT;
                rot_k_d = '0;
                found_d = 1'b0;
              end
            end
            alid_pkg::MODE_UPD_IDX: begin
              push = 1'b1;
              if (pos_bad) begin
                rstat_d = alid_pkg::ST_INVALID;
              end else begin
                cell_ctl.op = alid_pkg::CELL_WRITE;
                ridx_d      = pos_idx;
              end
            end
            default: begin
              push    = 1'b1;
              rstat_d = alid_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_ROT: begin
        // traverse steps only when its result can be stored
        if (!is_trav || slot_free) begin
          cell_ctl.op   = alid_pkg::CELL_ROTATE;
          cell_ctl.data = cell_word[0];
          if (is_trav) begin
            push    = 1'b1;
            rword_d = cell_word[0];
            ridx_d  = rot_k_q;
            rlast_d = (rot_k_q == last_idx);
          end else if (hit && !found_q) begin
            // first match gets the new word as it wraps around
            cell_ctl.data = nw_q;
            found_d       = 1'b1;
            fidx_d        = rot_k_q;
          end
          if (rot_k_q == last_idx) begin
            state_d = is_trav ? S_IDLE : S_REPORT;
          end else begin
            rot_k_d = rot_k_q + IDX_W'(1);
          end
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          push    = 1'b1;
          state_d = S_IDLE;
          if (found_q) begin
            ridx_d = fidx_q;
          end else begin
            rstat_d = alid_pkg::ST_NOTFOUND;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rot_k_q <= '0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rot_k_q <= rot_k_d;
      found_q <= found_d;
      fidx_q  <= fidx_d;
      if (push) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // command and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      mode_q <= cmd_i.mode;
      pos_q  <= cmd_i.position;
      nw_q   <= cmd_i.new_word;
      mw_q   <= cmd_i.match_word;
    end
    if (push) begin
      rword_q <= rword_d;
      ridx_q  <= ridx_d;
      rstat_q <= rstat_d;
      rcnt_q  <= count_d;
      rlast_q <= rlast_d;
    end
  end

  // chain of cells, each cell sees both neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    alid_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .pos_i   (cell_pos),
      .last_i  (last_idx),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[g])
    );
  end

  assign cmd_i.ready      = (state_q == S_IDLE);
  assign res_o.valid      = ov_q;
  assign res_o.word_out   = rword_q;
  assign res_o.word_index = alid_pkg::WIDX_W'(ridx_q);
  assign res_o.status     = rstat_q;
  assign res_o.count_out  = alid_pkg::COUNT_W'(rcnt_q);
  assign res_o.last       = rlast_q;

  `ALID_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY))
  `ALID_ASSERT(a_rot_in_range, (state_q == S_ROT) |-> (rot_k_q <= last_idx))
  `ALID_ASSERT_NEVER(a_no_overwrite, push && ov_q && !res_o.ready)
  `ALID_ASSERT(a_count_only_exec, (state_q != S_EXEC) |=> $stable(count_q))

endmodule
